// ===== hw/rtl/frqt_pkg.sv =====
// Shared constants for the quarter-turn frame rotator.
package frqt_pkg;

  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned DIM_CFG_W  = 7;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd2;

  // Rotation modes; the unused code behaves as a 90 degree turn
  localparam logic [MODE_W-1:0] MODE_ROT90  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROT180 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROT270 = 2'd2;

  // Request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

endpackage

// ===== hw/rtl/frqt_if.sv =====
// Handshake channel interfaces: pixel requests, rotated pixels, register writes.
interface frqt_req_if;
  import frqt_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [PIXEL_W-1:0] in_pixel;
  modport source (output valid, func, in_pixel, input ready);
  modport sink   (input valid, func, in_pixel, output ready);
endinterface

interface frqt_rsp_if;
  import frqt_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] out_pixel;
  logic               last;
  modport source (output valid, out_pixel, last, input ready);
  modport sink   (input valid, out_pixel, last, output ready);
endinterface

interface frqt_cfg_if;
  import frqt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/frqt_store.sv =====
// Frame memory with one write port, one read port and registered read data.
module frqt_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [frqt_pkg::PIXEL_W-1:0]  wr_data_i,
  input  logic                          rd_en_i,
  input  logic [AW-1:0]                 rd_addr_i,
  output logic [frqt_pkg::PIXEL_W-1:0]  rd_data_o
);
  import frqt_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/frame_rotate_quarter_turns.sv =====
// Quarter-turn frame rotator: top level with counters, address logic and output stage.
//
// Usage: write a frame of frame_width x frame_height pixels in raster order
// with func=0 requests on req_i; writes past the frame size are dropped.
// Once the frame is full, each func=1 request returns one pixel of the
// rotated frame on rsp_o; reads before that are dropped without a result.
// The final pixel carries last=1 and the frame counters clear for the next
// frame. Registers (mode, width, height) are to be written on cfg_i only
// while idle, which the block does not enforce; cfg_i is always ready.
// Throughput: one request per cycle while req_i.ready is high; each request
// is one write or one read of the frame memory.
// A read request's pixel goes through the memory read register, then the
// output register, before it is on rsp_o.
// Stall: up to two results are held (memory read stage and output register);
// req_i.ready drops only when both are full and rsp_o.ready is low.
// Reset: counters clear, mode becomes rotate 90, width and height become 64.
// Frame memory contents are not cleared; no clearing pass is run.
module frame_rotate_quarter_turns #(
  parameter int unsigned MAX_DIM     = 64,
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  frqt_req_if.sink    req_i,
  frqt_rsp_if.source  rsp_o,
  frqt_cfg_if.sink    cfg_i
);
  import frqt_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned CW = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int unsigned AW = $clog2(STORE_DEPTH);

  // Configuration registers
  logic [MODE_W-1:0]    mode_q;
  logic [DIM_CFG_W-1:0] width_q;
  logic [DIM_CFG_W-1:0] height_q;

  // Frame counters
  logic [CW-1:0] wr_cnt_q, wr_cnt_d;
  logic [CW-1:0] rd_cnt_q, rd_cnt_d;
  logic [CW-1:0] col_idx_q, col_idx_d;
  logic [DW-1:0] row_idx_q, row_idx_d;

  // Read stage and output register
  logic               p1_valid_q, p1_valid_d;
  logic               p1_zero_q;
  logic               p1_last_q;
  logic               out_valid_q;
  logic [PIXEL_W-1:0] out_pixel_q;
  logic               out_last_q;

  logic [DW-1:0]      w, h;
  logic [2*DW-1:0]    n_full;
  logic [CW-1:0]      n;
  logic               full;
  logic               accept, out_adv;
  logic               wr_en, rd_en;
  logic [31:0]        wr_ext;
  logic               wr_in_store;
  logic [CW-1:0]      rd_addr;
  logic [31:0]        rd_ext;
  logic               rd_sel_ok;
  logic               rd_zero;
  logic [DW-1:0]      col_sel, row_sel;
  logic [2*DW-1:0]    row_base;
  logic [DW-1:0]      row_inc;
  logic [CW-1:0]      rd_inc;
  logic               rd_last;
  logic [PIXEL_W-1:0] mem_rdata;

  // Effective dimensions: zero acts as one, oversize acts as MAX_DIM
  always_comb begin
    priority if (width_q == '0) begin
      w = DW'(1);
    end else if (32'(width_q) > 32'(MAX_DIM)) begin
      w = DW'(MAX_DIM);
    end else begin
      w = DW'(width_q);
    end
    priority if (height_q == '0) begin
      h = DW'(1);
    end else if (32'(height_q) > 32'(MAX_DIM)) begin
      h = DW'(MAX_DIM);
    end else begin
      h = DW'(height_q);
    end
  end

  assign n_full = w * h;
  assign n      = n_full[CW-1:0];
  assign full   = (wr_cnt_q >= n);

  // Configuration channel
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ROT90;
      width_q  <= DIM_CFG_W'(64);
      height_q <= DIM_CFG_W'(64);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ROTATION_MODE: mode_q   <= cfg_i.data[MODE_W-1:0];
        REG_FRAME_WIDTH:   width_q  <= cfg_i.data[DIM_CFG_W-1:0];
        REG_FRAME_HEIGHT:  height_q <= cfg_i.data[DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign out_adv     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !p1_valid_q || out_adv;
  assign accept      = req_i.valid && req_i.ready;
  assign wr_en       = accept && (req_i.func == FUNC_WRITE) && !full;
  assign rd_en       = accept && (req_i.func == FUNC_READ) && full;

  assign wr_ext      = 32'(wr_cnt_q);
  assign wr_in_store = wr_ext < 32'(STORE_DEPTH);

  // Readout address
  always_comb begin
    if (mode_q == MODE_ROT270) begin
      col_sel = w - DW'(1) - col_idx_q[DW-1:0];
      row_sel = row_idx_q;
    end else begin
      col_sel = col_idx_q[DW-1:0];
      row_sel = h - DW'(1) - row_idx_q;
    end
    row_base = row_sel * w;
    if (mode_q == MODE_ROT180) begin
      rd_sel_ok = rd_cnt_q < n;
      rd_addr   = n - CW'(1) - rd_cnt_q;
    end else begin
      rd_sel_ok = (col_idx_q < CW'(w)) && (row_idx_q < h);
      rd_addr   = row_base[CW-1:0] + CW'(col_sel);
    end
  end

  assign rd_ext  = 32'(rd_addr);
  assign rd_zero = !rd_sel_ok || !(rd_ext < 32'(STORE_DEPTH));

  assign row_inc = row_idx_q + DW'(1);
  assign rd_inc  = rd_cnt_q + CW'(1);
  assign rd_last = rd_inc >= n;

  // Counter updates
  always_comb begin
    wr_cnt_d  = wr_cnt_q;
    rd_cnt_d  = rd_cnt_q;
    col_idx_d = col_idx_q;
    row_idx_d = row_idx_q;
    if (wr_en) begin
      wr_cnt_d = wr_cnt_q + CW'(1);
    end
    if (rd_en) begin
      if (rd_last) begin
        wr_cnt_d  = '0;
        rd_cnt_d  = '0;
        col_idx_d = '0;
        row_idx_d = '0;
      end else begin
        rd_cnt_d = rd_inc;
        if (row_inc >= h) begin
          row_idx_d = '0;
          col_idx_d = col_idx_q + CW'(1);
        end else begin
          row_idx_d = row_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q  <= '0;
      rd_cnt_q  <= '0;
      col_idx_q <= '0;
      row_idx_q <= '0;
    end else begin
      wr_cnt_q  <= wr_cnt_d;
      rd_cnt_q  <= rd_cnt_d;
      col_idx_q <= col_idx_d;
      row_idx_q <= row_idx_d;
    end
  end

  frqt_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en && wr_in_store),
    .wr_addr_i (wr_ext[AW-1:0]),
    .wr_data_i (req_i.in_pixel),
    .rd_en_i   (rd_en && !rd_zero),
    .rd_addr_i (rd_ext[AW-1:0]),
    .rd_data_o (mem_rdata)
  );

  // Read stage: an accept only happens when this stage is empty or moving on
  always_comb begin
    if (accept) begin
      p1_valid_d = rd_en;
    end else if (out_adv) begin
      p1_valid_d = 1'b0;
    end else begin
      p1_valid_d = p1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= p1_valid_d;
      if (out_adv) begin
        out_valid_q <= p1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      p1_zero_q <= rd_zero;
      p1_last_q <= rd_last;
    end
    if (out_adv && p1_valid_q) begin
      out_pixel_q <= p1_zero_q ? '0 : mem_rdata;
      out_last_q  <= p1_last_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out_pixel = out_pixel_q;
  assign rsp_o.last      = out_last_q;

`ifndef SYNTHESIS
  a_drop_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !rd_en) |=> !p1_valid_q)
    else $error("dropped request produced a result");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && rd_last) |=> (wr_cnt_q == '0 && rd_cnt_q == '0 && col_idx_q == '0))
    else $error("counters not cleared after last pixel");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_idx_q) < 32'(MAX_DIM))
    else $error("row index out of range");

  a_wr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wr_cnt_q) <= 32'(MAX_DIM * MAX_DIM))
    else $error("write count out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (p1_valid_q && out_valid_q && !rsp_o.ready))
    else $error("request side stalled without a full pipeline");
`endif

endmodule

// ===== verif/frame_rotate_quarter_turns_tb.sv =====
// Self-checking testbench for the quarter-turn frame rotator.
module frame_rotate_quarter_turns_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import frqt_pkg::*;

  localparam int unsigned MAX_DIM      = 64;
  localparam int unsigned STORE_DEPTH  = 4096;
  localparam int unsigned STORE_AW     = $clog2(STORE_DEPTH);
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE_CYC   = 4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } rot_pixel_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  frqt_req_if req_if ();
  frqt_rsp_if rsp_if ();
  frqt_cfg_if cfg_if ();

  frame_rotate_quarter_turns #(
    .MAX_DIM    (MAX_DIM),
    .STORE_DEPTH(STORE_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state
  logic [PIXEL_W-1:0]   px_store [STORE_DEPTH];
  logic [12:0]          wr_cnt = '0;
  logic [12:0]          rd_cnt = '0;
  // wide on purpose: a mid-frame resize can push the walk past the frame
  int unsigned          col_pos = 0;
  int unsigned          row_pos = 0;
  logic [MODE_W-1:0]    cfg_mode   = MODE_ROT90;
  logic [DIM_CFG_W-1:0] cfg_width  = 7'd64;
  logic [DIM_CFG_W-1:0] cfg_height = 7'd64;

  rot_pixel_t  pending_pixels [$];
  bit          frame_done;
  bit          no_idle;
  int unsigned applied_cnt;
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  function automatic int unsigned dim_clamp(input logic [DIM_CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return 32'(d);
  endfunction

  function automatic int unsigned frame_pixels();
    return dim_clamp(cfg_width) * dim_clamp(cfg_height);
  endfunction

  function automatic logic [PIXEL_W-1:0] store_word(input int unsigned addr);
    return (addr < STORE_DEPTH) ? px_store[addr[STORE_AW-1:0]] : '0;
  endfunction

  function automatic void predict_rotation(input logic fn, input logic [PIXEL_W-1:0] pix);
    int unsigned w, h, n, col, row;
    rot_pixel_t  res;
    w = dim_clamp(cfg_width);
    h = dim_clamp(cfg_height);
    n = w * h;
    if (fn == FUNC_WRITE) begin
      if (wr_cnt < n) begin
        if (wr_cnt < STORE_DEPTH) px_store[wr_cnt[STORE_AW-1:0]] = pix;
        wr_cnt++;
        applied_cnt++;
      end
      return;
    end
    // drop reads until the frame is full
    if (wr_cnt < n) return;
    res.pixel = '0;
    if (cfg_mode == MODE_ROT180) begin
      if (rd_cnt < n) res.pixel = store_word(n - 1 - rd_cnt);
    end else if (col_pos < w && row_pos < h) begin
      if (cfg_mode == MODE_ROT270) begin
        col = w - 1 - col_pos;
        row = row_pos;
      end else begin
        col = col_pos;
        row = h - 1 - row_pos;
      end
      res.pixel = store_word(row * w + col);
    end
    rd_cnt++;
    row_pos++;
    if (row_pos >= h) begin
      row_pos = 0;
      col_pos++;
    end
    res.last = (rd_cnt >= n);
    if (res.last) begin
      wr_cnt     = '0;
      rd_cnt     = '0;
      col_pos    = 0;
      row_pos    = 0;
      frame_done = 1'b1;
    end
    pending_pixels.push_back(res);
    applied_cnt++;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ROTATION_MODE: cfg_mode   = data[MODE_W-1:0];
      REG_FRAME_WIDTH:   cfg_width  = data;
      REG_FRAME_HEIGHT:  cfg_height = data;
      default: ;
    endcase
  endfunction

  task automatic report_failure(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Response side: random stall per result, check against oldest expectation
  initial begin
    int         hold_cnt;
    rot_pixel_t exp_px;
    hold_cnt = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (pending_pixels.size() == 0) begin
          report_failure($sformatf("unexpected pixel %h last %b",
                                   rsp_if.out_pixel, rsp_if.last));
        end else begin
          exp_px = pending_pixels.pop_front();
          if (rsp_if.out_pixel !== exp_px.pixel)
            report_failure($sformatf("out_pixel mismatch: expected %h, got %h",
                                     exp_px.pixel, rsp_if.out_pixel));
          if (rsp_if.last !== exp_px.last)
            report_failure($sformatf("last mismatch: expected %b, got %b",
                                     exp_px.last, rsp_if.last));
        end
        hold_cnt = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (hold_cnt > 0) begin
        rsp_if.ready <= 1'b0;
        hold_cnt--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Hold valid high across back-to-back requests; drop it only for a gap
  task automatic send_req(input logic fn, input logic [PIXEL_W-1:0] pix);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.func     <= fn;
    req_if.in_pixel <= pix;
    do @(posedge clk_i); while (!req_if.ready);
    predict_rotation(fn, pix);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  task automatic wait_idle();
    drain_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_register(idx, data);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] mode_data,
                              input logic [CFG_DATA_W-1:0] w,
                              input logic [CFG_DATA_W-1:0] h);
    wait_idle();
    cfg_write(REG_ROTATION_MODE, mode_data);
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    cfg_if.valid <= 1'b0;
  endtask

  // Fill, then drain unless stop_after ends it; noise requests land where dropped
  task automatic run_frame(input int noise_pct, input int stop_after);
    int sent;
    bit noise;
    bit filling;
    sent       = 0;
    frame_done = 1'b0;
    while (!frame_done && (stop_after == 0 || sent < stop_after)) begin
      noise   = ($urandom_range(0, 99) < noise_pct);
      filling = (wr_cnt < frame_pixels());
      if (filling != noise) send_req(FUNC_WRITE, $urandom());
      else send_req(FUNC_READ, $urandom());
      sent++;
      if ($urandom_range(0, 63) == 0) drain_results();
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] draw_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(65, 127));
      2:       return CFG_DATA_W'($urandom_range(9, 64));
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic program_random_config();
    logic [CFG_DATA_W-1:0] w, h;
    w = draw_dim();
    h = draw_dim();
    // keep most frames small
    if (dim_clamp(w) * dim_clamp(h) > 256) h = CFG_DATA_W'($urandom_range(1, 4));
    program_regs(CFG_DATA_W'($urandom_range(0, 127)), w, h);
  endtask

  task automatic test_reset_full_frame();
    send_req(FUNC_READ, $urandom());
    run_frame(5, 0);
  endtask

  task automatic test_each_rotation();
    logic [MODE_W-1:0] modes [3] = '{MODE_ROT90, MODE_ROT180, MODE_ROT270};
    foreach (modes[i]) begin
      program_regs({{(CFG_DATA_W-MODE_W){1'b0}}, modes[i]}, 7'd2, 7'd2);
      send_req(FUNC_READ, $urandom());
      send_req(FUNC_WRITE, 32'h0000_0000);
      send_req(FUNC_WRITE, 32'hFFFF_FFFF);
      send_req(FUNC_WRITE, $urandom());
      send_req(FUNC_WRITE, $urandom());
      send_req(FUNC_WRITE, $urandom());
      repeat (4) send_req(FUNC_READ, $urandom());
    end
  endtask

  task automatic test_dim_clamp();
    wait_idle();
    cfg_write(REG_UNUSED, 7'h7F);
    cfg_write(REG_ROTATION_MODE, 7'h7F);
    cfg_write(REG_FRAME_WIDTH, 7'd0);
    cfg_write(REG_FRAME_HEIGHT, 7'd0);
    cfg_if.valid <= 1'b0;
    send_req(FUNC_WRITE, 32'hFFFF_FFFF);
    send_req(FUNC_READ, 32'hFFFF_FFFF);
    program_regs({{(CFG_DATA_W-MODE_W){1'b0}}, MODE_ROT270}, 7'd127, 7'd1);
    run_frame(0, 0);
    program_regs({{(CFG_DATA_W-MODE_W){1'b0}}, MODE_ROT180}, 7'd1, 7'd127);
    run_frame(0, 0);
  endtask

  task automatic test_mid_frame_change();
    // shrink during fill, shrink during readout, grow during fill
    program_regs({{(CFG_DATA_W-MODE_W){1'b0}}, MODE_ROT90}, 7'd4, 7'd4);
    run_frame(0, 6);
    program_regs({{(CFG_DATA_W-MODE_W){1'b0}}, MODE_ROT180}, 7'd2, 7'd2);
    run_frame(0, 0);
    program_regs({{(CFG_DATA_W-MODE_W){1'b0}}, MODE_ROT270}, 7'd3, 7'd3);
    run_frame(0, 13);
    program_regs({{(CFG_DATA_W-MODE_W){1'b0}}, MODE_ROT90}, 7'd2, 7'd4);
    run_frame(0, 0);
    program_regs({{(CFG_DATA_W-MODE_W){1'b0}}, MODE_ROT270}, 7'd2, 7'd2);
    run_frame(0, 3);
    program_regs({{(CFG_DATA_W-MODE_W){1'b0}}, MODE_ROT180}, 7'd4, 7'd4);
    run_frame(0, 0);
  endtask

  task automatic test_random_frames();
    int unsigned base;
    base = applied_cnt;
    while (applied_cnt - base < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      program_random_config();
      if ($urandom_range(0, 7) == 0) begin
        run_frame(10, $urandom_range(1, 2 * frame_pixels()));
        program_random_config();
      end
      run_frame(10, 0);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    req_if.valid    <= 1'b0;
    req_if.func     <= FUNC_WRITE;
    req_if.in_pixel <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_ROTATION_MODE;
    cfg_if.data     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_full_frame();
    test_each_rotation();
    test_dim_clamp();
    test_mid_frame_change();
    test_random_frames();

    wait_idle();
    if (err_cnt == 0 && pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
